[hw/rtl/sil_pkg.sv]
// sil_pkg: shared types and constants of the sorted insertion list
// holds the entry, status, action, cell command and control state types
// no dependencies
package sil_pkg;

  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 32;

  // one stored list entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    payload;
  } entry_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_DROPPED  = 2'd1,
    STATUS_ENTRY    = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  // input action codes
  typedef enum logic {
    ACTION_INSERT  = 1'b0,
    ACTION_READOUT = 1'b1
  } action_t;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctrl_t;

  // control sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

[hw/rtl/sil_ifs.sv]
// sil_ifs: valid/ready channel interfaces of the sorted insertion list
// one interface for request items and one for result items
// depends on sil_pkg
interface sil_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [sil_pkg::KEY_W-1:0]      key;
  logic [sil_pkg::PAYLOAD_W-1:0]         payload;

  modport source (output valid, action, key, payload, input ready);
  modport sink (input valid, action, key, payload, output ready);
endinterface

interface sil_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            status;
  logic signed [sil_pkg::KEY_W-1:0]      out_key;
  logic [sil_pkg::PAYLOAD_W-1:0]         out_payload;
  logic                                  last;

  modport source (output valid, status, out_key, out_payload, last, input ready);
  modport sink (input valid, status, out_key, out_payload, last, output ready);
endinterface

[hw/rtl/sil_cell.sv]
// sil_cell: one position of the sorted insertion chain
// compares the new key against its own entry and shifts or rotates with its neighbors
// depends on sil_pkg
module sil_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  sil_pkg::cell_ctrl_t ctrl,
  input  sil_pkg::entry_t     left_entry,
  input  logic                left_valid,
  input  logic                left_take,
  input  sil_pkg::entry_t     right_entry,
  input  logic                right_valid,
  input  sil_pkg::entry_t     head_entry,
  output sil_pkg::entry_t     entry,
  output logic                valid,
  output logic                take
);

  logic key_hit;

  // head goes strictly before, later cells take a key at or above the new one
  always_comb begin
    if (IS_HEAD) begin
      key_hit = (ctrl.new_entry.key < entry.key);
    end else begin
      key_hit = (entry.key >= ctrl.new_entry.key);
    end
    take = !valid || key_hit;
  end

  // occupancy bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.op == sil_pkg::CELL_INSERT) begin
      valid <= valid | left_valid;
    end
  end

  // entry data: shift right on insert, rotate toward the head on readout
  always_ff @(posedge clk) begin
    case (ctrl.op)
      sil_pkg::CELL_INSERT: begin
        if (left_take) begin
          entry <= left_entry;
        end else if (take) begin
          entry <= ctrl.new_entry;
        end
      end
      sil_pkg::CELL_ROTATE: begin
        if (valid) begin
          if (right_valid) begin
            entry <= right_entry;
          end else begin
            entry <= head_entry;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/sorted_insert_list.sv]
// sorted_insert_list: top level of the sorted insertion list
// instantiates a chain of sil_cell and the control sequencer with the result register
// depends on sil_pkg, sil_ifs and sil_cell
//
// Keeps up to CAPACITY (key, payload) entries in ascending signed key order.
// Request channel in_ch: action 0 inserts (key, payload), action 1 reads out.
// Result channel out_ch: status, out_key, out_payload and last per result item.
// An insert compares in every cell at once and shifts the chain at acceptance;
// its single result (inserted or dropped when full) appears the cycle after
// acceptance, and a new item is taken every cycle while the receiver keeps up.
// A readout rotates the chain toward the head one position a cycle while the
// receiver keeps up and emits the head entry each time: N entries give N results,
// the last one marked; the chain is back in order once all N have been emitted.
// An empty list answers a readout with one empty-status result next cycle.
// No new item is taken during a readout.
// A single result register parts the two sides: when the receiver stalls the
// result holds, the chain stops rotating and in_ch.ready drops.
// Reset (rst, synchronous) empties the list and clears any pending result.
module sorted_insert_list #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst,
  sil_in_if.sink        in_ch,
  sil_out_if.source     out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  sil_pkg::entry_t     entries [CAPACITY];
  logic                valids  [CAPACITY];
  logic                takes   [CAPACITY];
  sil_pkg::cell_ctrl_t ctrl;

  sil_pkg::state_t     state, state_next;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    idx;

  logic                out_valid;
  sil_pkg::status_t    out_status;
  sil_pkg::entry_t     out_entry;
  logic                out_last;

  logic                slot_free;
  logic                accept;
  logic                full;
  logic                read_last;
  logic                load_out;
  sil_pkg::status_t    load_status;
  sil_pkg::entry_t     load_entry;
  logic                load_last;
  logic                count_inc;
  logic                idx_clear;
  logic                idx_inc;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sil_pkg::entry_t l_entry;
    logic            l_valid;
    logic            l_take;
    sil_pkg::entry_t r_entry;
    logic            r_valid;

    if (i == 0) begin : g_left_head
      assign l_entry = '0;
      assign l_valid = 1'b1;
      assign l_take  = 1'b0;
    end else begin : g_left_chain
      assign l_entry = entries[i-1];
      assign l_valid = valids[i-1];
      assign l_take  = takes[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_tail
      assign r_entry = entries[0];
      assign r_valid = 1'b0;
    end else begin : g_right_chain
      assign r_entry = entries[i+1];
      assign r_valid = valids[i+1];
    end

    sil_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_take   (l_take),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .head_entry  (entries[0]),
      .entry       (entries[i]),
      .valid       (valids[i]),
      .take        (takes[i])
    );
  end

  // handshake and status terms
  assign slot_free   = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == sil_pkg::ST_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count == CNT_W'(CAPACITY));
  assign read_last   = ((CNT_W'(idx) + CNT_W'(1)) == count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sil_pkg::ST_IDLE: begin
        if (accept && (in_ch.action == sil_pkg::ACTION_READOUT) && (count != '0)) begin
          state_next = sil_pkg::ST_READ;
        end
      end
      sil_pkg::ST_READ: begin
        if (slot_free && read_last) begin
          state_next = sil_pkg::ST_IDLE;
        end
      end
      default: state_next = sil_pkg::ST_IDLE;
    endcase
  end

  // chain command and result load
  always_comb begin
    ctrl.op                = sil_pkg::CELL_HOLD;
    ctrl.new_entry.key     = in_ch.key;
    ctrl.new_entry.payload = in_ch.payload;
    load_out               = 1'b0;
    load_status            = sil_pkg::STATUS_INSERTED;
    load_entry             = '0;
    load_last              = 1'b1;
    count_inc              = 1'b0;
    idx_clear              = 1'b0;
    idx_inc                = 1'b0;
    case (state)
      sil_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.action == sil_pkg::ACTION_INSERT) begin
            load_out = 1'b1;
            if (full) begin
              load_status = sil_pkg::STATUS_DROPPED;
            end else begin
              ctrl.op   = sil_pkg::CELL_INSERT;
              count_inc = 1'b1;
            end
          end else if (count == '0) begin
            load_out    = 1'b1;
            load_status = sil_pkg::STATUS_EMPTY;
          end else begin
            idx_clear = 1'b1;
          end
        end
      end
      sil_pkg::ST_READ: begin
        if (slot_free) begin
          ctrl.op     = sil_pkg::CELL_ROTATE;
          load_out    = 1'b1;
          load_status = sil_pkg::STATUS_ENTRY;
          load_entry  = entries[0];
          load_last   = read_last;
          idx_inc     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sil_pkg::ST_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (count_inc) begin
        count <= count + CNT_W'(1);
      end
      if (idx_clear) begin
        idx <= '0;
      end else if (idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= load_status;
      out_entry  <= load_entry;
      out_last   <= load_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.out_key     = out_entry.key;
  assign out_ch.out_payload = out_entry.payload;
  assign out_ch.last        = out_last;

endmodule
